// File: src/http_chunked_body_decoder_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared property shapes used by the port checker.
// ---------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HCBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbd check failed");

// Next-cycle implication, disabled during reset
`define HCBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd check failed");

`endif

// File: src/hcbd_pkg.sv
// ---------------------------------------------------------------------------
// Chunked body decoder package
// Shared constants, token and result records, parser phases.
// ---------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int TOTAL_W   = 32;
    localparam int SUM_W     = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_LOW_A   = 8'd97;
    localparam logic [7:0] CH_LOW_F   = 8'd102;
    localparam logic [7:0] CH_UP_A    = 8'd65;
    localparam logic [7:0] CH_UP_F    = 8'd70;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    // Queue depth on both sides of the parser
    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        TK_HEX,
        TK_CR,
        TK_LF,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        logic [7:0] data;
        tok_kind_t  kind;
        logic [3:0] digit;
    } tok_t;

    typedef struct packed {
        logic [7:0]         payload_byte;
        logic               is_payload;
        logic               body_done;
        logic               format_error;
        logic [TOTAL_W-1:0] total_bytes;
    } res_t;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE,
        PH_ERROR
    } phase_t;

endpackage

// File: src/hcbd_front.sv
// ---------------------------------------------------------------------------
// Chunked body decoder front end
// Accepts raw bytes, classifies them and holds them in a short token queue.
// ---------------------------------------------------------------------------
module hcbd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    in_byte,
    input  logic          push,
    output logic          full,
    output hcbd_pkg::tok_t tok,
    output logic          tok_valid,
    input  logic          tok_ready
);
    import hcbd_pkg::*;

    tok_t              slot_reg [QDEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    tok_t              cls;
    logic              do_push;
    logic              do_pop;

    // Classify the incoming byte
    always_comb
    begin
        cls.data  = in_byte;
        cls.kind  = TK_OTHER;
        cls.digit = '0;
        if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
        begin
            cls.kind  = TK_HEX;
            cls.digit = 4'(in_byte - CH_ZERO);
        end
        else if (in_byte >= CH_LOW_A && in_byte <= CH_LOW_F)
        begin
            cls.kind  = TK_HEX;
            cls.digit = 4'(in_byte - CH_LOW_A) + HEX_TEN;
        end
        else if (in_byte >= CH_UP_A && in_byte <= CH_UP_F)
        begin
            cls.kind  = TK_HEX;
            cls.digit = 4'(in_byte - CH_UP_A) + HEX_TEN;
        end
        else if (in_byte == CH_CR)
        begin
            cls.kind = TK_CR;
        end
        else if (in_byte == CH_LF)
        begin
            cls.kind = TK_LF;
        end
    end

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign tok_valid = (count_reg != '0);
    assign tok       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = tok_valid && tok_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the classified request in the queue
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: src/hcbd_back.sv
// ---------------------------------------------------------------------------
// Chunked body decoder back end
// Runs the chunk parser on classified tokens and queues the results.
// ---------------------------------------------------------------------------
module hcbd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hcbd_pkg::tok_t tok,
    input  logic           tok_valid,
    output logic           tok_ready,
    output hcbd_pkg::res_t res,
    output logic           res_valid,
    input  logic           res_pop
);
    import hcbd_pkg::*;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] size_next;
    logic                 seen_reg;
    logic                 seen_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [SUM_W-1:0]     sum;
    logic                 take;
    logic                 emit;
    res_t                 res_new;
    logic                 ovf;

    res_t                 rq_reg [QDEPTH];
    logic                 rq_wr_reg;
    logic                 rq_rd_reg;
    logic [QCNT_W-1:0]    rq_cnt_reg;
    logic [QCNT_W-1:0]    rq_cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign tok_ready = (rq_cnt_reg != QCNT_W'(QDEPTH));
    assign take      = tok_valid && tok_ready;
    assign ovf       = (size_reg[SIZE_BITS-1 -: 4] != '0);
    assign sum       = SUM_W'(total_reg) + SUM_W'(size_reg);

    // Next parser state
    always_comb
    begin
        phase_next = phase_reg;
        size_next  = size_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (tok.kind == TK_CR)
                    begin
                        phase_next = seen_reg ? PH_SIZE_LF : PH_ERROR;
                    end
                    else if (tok.kind != TK_HEX || ovf)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        size_next = {size_reg[SIZE_BITS-5:0], tok.digit};
                        seen_next = 1'b1;
                    end
                end
                PH_SIZE_LF:
                begin
                    if (tok.kind != TK_LF)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        seen_next = 1'b0;
                        if (size_reg == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            if (sum >= SUM_W'(TOTAL_MAX))
                            begin
                                total_next = TOTAL_MAX;
                            end
                            else
                            begin
                                total_next = sum[TOTAL_W-1:0];
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    size_next = size_reg - SIZE_BITS'(1);
                    if (size_reg == SIZE_BITS'(1))
                    begin
                        phase_next = PH_DATA_CR;
                    end
                end
                PH_DATA_CR:
                begin
                    phase_next = (tok.kind == TK_CR) ? PH_DATA_LF : PH_ERROR;
                end
                PH_DATA_LF:
                begin
                    if (tok.kind == TK_LF)
                    begin
                        phase_next = PH_SIZE;
                        size_next  = '0;
                        seen_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result for the current request
    always_comb
    begin
        emit        = 1'b0;
        res_new     = '0;
        res_new.total_bytes = total_reg;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if ((tok.kind == TK_CR && !seen_reg) ||
                    (tok.kind != TK_CR && (tok.kind != TK_HEX || ovf)))
                begin
                    emit                 = 1'b1;
                    res_new.format_error = 1'b1;
                end
            end
            PH_SIZE_LF:
            begin
                if (tok.kind != TK_LF)
                begin
                    emit                 = 1'b1;
                    res_new.format_error = 1'b1;
                end
                else if (size_reg == '0)
                begin
                    emit              = 1'b1;
                    res_new.body_done = 1'b1;
                end
            end
            PH_DATA:
            begin
                emit                 = 1'b1;
                res_new.is_payload   = 1'b1;
                res_new.payload_byte = tok.data;
            end
            PH_DATA_CR:
            begin
                if (tok.kind != TK_CR)
                begin
                    emit                 = 1'b1;
                    res_new.format_error = 1'b1;
                end
            end
            PH_DATA_LF:
            begin
                if (tok.kind != TK_LF)
                begin
                    emit                 = 1'b1;
                    res_new.format_error = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            size_reg  <= '0;
            seen_reg  <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            seen_reg  <= seen_next;
            total_reg <= total_next;
        end
    end

    // Result queue
    assign do_push   = take && emit;
    assign res_valid = (rq_cnt_reg != '0);
    assign do_pop    = res_valid && res_pop;
    assign res       = rq_reg[rq_rd_reg];

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (do_push && !do_pop)
        begin
            rq_cnt_next = rq_cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            rq_cnt_next = rq_cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            rq_wr_reg  <= do_push ? ~rq_wr_reg : rq_wr_reg;
            rq_rd_reg  <= do_pop ? ~rq_rd_reg : rq_rd_reg;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            rq_reg[rq_wr_reg] <= res_new;
        end
    end

endmodule

// File: src/http_chunked_body_decoder_core.sv
// ---------------------------------------------------------------------------
// HTTP chunked body decoder
// Parses a chunked transfer body byte by byte and emits payload, end and
// error results.
// ---------------------------------------------------------------------------
// Channel   Handshake         Payload
// input     push / full       in_byte
// result    pop / empty       payload_byte, is_payload, body_done,
//                             format_error, total_bytes
//
// One byte per cycle sustained while the result side keeps up; a result
// reaches the result ports through the token queue, then the parser into
// the result queue, both registered.
// Reset is asynchronous and returns the parser to the size line.
// A stalled result side fills the two-entry result queue, then the parser
// holds and the two-entry token queue raises full.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    in_byte,
    input  logic                          push,
    output logic                          full,
    output logic [7:0]                    payload_byte,
    output logic                          is_payload,
    output logic                          body_done,
    output logic                          format_error,
    output logic [hcbd_pkg::TOTAL_W-1:0]  total_bytes,
    output logic                          empty,
    input  logic                          pop
);
    import hcbd_pkg::*;

    tok_t tok;
    logic tok_valid;
    logic tok_ready;
    res_t res;
    logic res_valid;

    hcbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .push      (push),
        .full      (full),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready)
    );

    hcbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    // Drive result ports
    assign empty        = !res_valid;
    assign payload_byte = res.payload_byte;
    assign is_payload   = res.is_payload;
    assign body_done    = res.body_done;
    assign format_error = res.format_error;
    assign total_bytes  = res.total_bytes;

endmodule

// File: src/hcbd_checker.sv
// ---------------------------------------------------------------------------
// Chunked body decoder port checker
// Watches the top-level ports for result ordering and content rules.
// ---------------------------------------------------------------------------
`include "http_chunked_body_decoder_core_macros.svh"

module hcbd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic [7:0]                   payload_byte,
    input logic                         is_payload,
    input logic                         body_done,
    input logic                         format_error,
    input logic [hcbd_pkg::TOTAL_W-1:0] total_bytes,
    input logic                         empty,
    input logic                         pop
);
    // A result carries at most one kind
    `HCBD_ASSERT_NOW(a_one_kind, !empty, $onehot0({is_payload, body_done, format_error}))

    // Non-payload results carry a zero byte
    `HCBD_ASSERT_NOW(a_zero_byte, !empty && !is_payload, payload_byte == 8'd0)

    // Nothing follows the final result
    `HCBD_ASSERT_NEXT(a_last, pop && !empty && (body_done || format_error), empty)

    // An untaken result stays offered
    `HCBD_ASSERT_NEXT(a_hold, !empty && !pop, !empty)

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (.*);
